>>> rtl/sid_pkg.sv
`default_nettype none
package sid_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int unsigned ANGLE_W     = 25;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned COUNT_W     = 7;

  // One memory word holds the special flag above the angle
  localparam int unsigned MEM_W       = ANGLE_W + 1;

  // 1.0 in units of 2^-24
  localparam logic [ANGLE_W-1:0] ONE_FX      = ANGLE_W'(1) << 24;
  localparam logic [ANGLE_W-1:0] TOL_RESET   = ANGLE_W'(17);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ADD   = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_MATCH  = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> rtl/sid_if.sv
`default_nettype none
// Request channel: one table operation
interface sid_in_if;
  logic                          valid;
  logic                          ready;
  logic [sid_pkg::OPCODE_W-1:0]  opcode;
  logic [sid_pkg::ANGLE_W-1:0]   angle_value;

  modport source (output valid, output opcode, output angle_value, input ready);
  modport sink   (input valid, input opcode, input angle_value, output ready);
endinterface

// Result channel: one result per request
interface sid_out_if;
  logic                          valid;
  logic                          ready;
  logic [sid_pkg::STATUS_W-1:0]  status;
  logic [sid_pkg::INDEX_W-1:0]   entry_index;
  logic [sid_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output entry_index, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input entry_index, input entry_count,
                  output ready);
endinterface

// Configuration write channel: dedup tolerance
interface sid_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sid_pkg::ANGLE_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/sid_ram.sv
`default_nettype none
module sid_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/sorted_insert_with_dedup_top.sv
// Sorted angle table with tolerance dedup.
// in_ch carries one request (opcode, angle_value): clear the table, append a
// base node in ascending order, or add an angle. An add finds the lower-bound
// position by binary search, returns the index of a neighbor strictly within
// the dedup tolerance, or else shifts the tail up and inserts the value.
// out_ch returns status, entry_index and entry_count, one result per request.
// cfg_ch writes the dedup tolerance; it is always ready.
// Sequence: clear, rejected and full requests, and a load onto an empty table,
// go straight to S_RES and the output register; a load onto a non-empty table
// first passes S_LD_CHK; an add runs the binary search (S_SRCH, S_SRCH_WT per
// probe), the neighbor checks (S_CHK_LO, S_CHK_HI), then S_SH_RD and S_SH_WR
// per tail entry moved, since each move is a read and a write of the single
// table memory. One request is in work at a time; a new one is accepted while
// the previous result still waits in the output register.
// Reset empties the table (count to zero) and sets the tolerance to 17; no
// memory sweep is needed. When out_ch stalls, a finished result waits in
// S_RES and no further request is taken until the output register frees.
`default_nettype none
module sorted_insert_with_dedup_top (
  input wire logic   clk,
  input wire logic   rst_n,
  sid_in_if.sink     in_ch,
  sid_out_if.source  out_ch,
  sid_cfg_if.sink    cfg_ch
);

  localparam int unsigned ADDR_W  = sid_pkg::ADDR_W;
  localparam int unsigned CNT_W   = sid_pkg::CNT_W;
  localparam int unsigned ANGLE_W = sid_pkg::ANGLE_W;
  localparam int unsigned MEM_W   = sid_pkg::MEM_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_CHK,
    S_SRCH,
    S_SRCH_WT,
    S_CHK_LO,
    S_CHK_HI,
    S_SH_RD,
    S_SH_WR,
    S_RES
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ANGLE_W-1:0]        x_r, x_nxt;
  logic [ANGLE_W-1:0]        tol_r, tol_nxt;
  logic [ADDR_W-1:0]         lo_r, lo_nxt;
  logic [ADDR_W-1:0]         hi_r, hi_nxt;
  logic [ADDR_W-1:0]         sh_r, sh_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  sid_pkg::status_t          res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]         res_idx_r, res_idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sid_pkg::status_t          out_status_r, out_status_nxt;
  logic [sid_pkg::INDEX_W-1:0] out_index_r, out_index_nxt;
  logic [sid_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [MEM_W-1:0]          wr_data;
  logic [ADDR_W-1:0]         rd_addr;
  logic [MEM_W-1:0]          rd_data;
  logic [ANGLE_W-1:0]        rd_angle;
  logic [ADDR_W-1:0]         mid;
  logic [CNT_W-1:0]          lo_ext;
  logic                      full;
  logic                      in_acc;

  // True when the two values lie strictly closer than the tolerance
  function automatic logic within_tol(input logic [ANGLE_W-1:0] a,
                                      input logic [ANGLE_W-1:0] b,
                                      input logic [ANGLE_W-1:0] tol);
    logic [ANGLE_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d < tol;
  endfunction

  sid_ram #(
    .WIDTH (MEM_W),
    .DEPTH (sid_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_angle     = rd_data[ANGLE_W-1:0];
  assign mid          = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_ext       = CNT_W'(lo_r);
  assign full         = count_r >= CNT_W'(sid_pkg::TABLE_DEPTH);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_index = out_index_r;
  assign out_ch.entry_count = out_count_r;

  // Sequence one request: clear, load, or for an add search, check neighbors, shift the tail, insert
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    tol_nxt        = tol_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    sh_nxt         = sh_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = sh_r;
    wr_data        = rd_data;
    rd_addr        = mid;

    // Take the tolerance register write
    if (cfg_ch.valid && cfg_ch.ready) begin
      tol_nxt = cfg_ch.data;
    end

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt          = in_ch.angle_value;
          res_idx_nxt    = '0;
          res_status_nxt = sid_pkg::ST_OK;
          lo_nxt         = '0;
          hi_nxt         = count_r[ADDR_W-1:0];
          rd_addr        = ADDR_W'(count_r - CNT_W'(1));
          state_nxt      = S_RES;
          case (in_ch.opcode)
            sid_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            sid_pkg::OP_LOAD: begin
              if (in_ch.angle_value > sid_pkg::ONE_FX) begin
                res_status_nxt = sid_pkg::ST_REJECT;
              end else if (full) begin
                res_status_nxt = sid_pkg::ST_FULL;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = {1'b0, in_ch.angle_value};
                count_nxt = CNT_W'(1);
              end else begin
                state_nxt = S_LD_CHK;
              end
            end
            sid_pkg::OP_ADD: begin
              if (in_ch.angle_value > sid_pkg::ONE_FX) begin
                res_status_nxt = sid_pkg::ST_REJECT;
              end else if (full) begin
                res_status_nxt = sid_pkg::ST_FULL;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            default: begin
              res_status_nxt = sid_pkg::ST_REJECT;
            end
          endcase
        end
      end

      // Append only above the last entry
      S_LD_CHK: begin
        state_nxt = S_RES;
        if (rd_angle >= x_r) begin
          res_status_nxt = sid_pkg::ST_REJECT;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = count_r[ADDR_W-1:0];
          wr_data     = {1'b0, x_r};
          res_idx_nxt = count_r[ADDR_W-1:0];
          count_nxt   = count_r + CNT_W'(1);
        end
      end

      // Probe the midpoint, or move on to the neighbor checks
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid;
          state_nxt = S_SRCH_WT;
        end else if (lo_r != '0) begin
          rd_addr   = lo_r - ADDR_W'(1);
          state_nxt = S_CHK_LO;
        end else if (lo_ext < count_r) begin
          rd_addr   = lo_r;
          state_nxt = S_CHK_HI;
        end else begin
          sh_nxt    = count_r[ADDR_W-1:0];
          state_nxt = S_SH_RD;
        end
      end

      // Narrow the search window
      S_SRCH_WT: begin
        if (rd_angle < x_r) begin
          lo_nxt = mid + ADDR_W'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH;
      end

      // Entry just below the position
      S_CHK_LO: begin
        if (within_tol(rd_angle, x_r, tol_r)) begin
          res_status_nxt = sid_pkg::ST_MATCH;
          res_idx_nxt    = lo_r - ADDR_W'(1);
          state_nxt      = S_RES;
        end else if (lo_ext < count_r) begin
          rd_addr   = lo_r;
          state_nxt = S_CHK_HI;
        end else begin
          sh_nxt    = count_r[ADDR_W-1:0];
          state_nxt = S_SH_RD;
        end
      end

      // Entry at the position
      S_CHK_HI: begin
        if (within_tol(rd_angle, x_r, tol_r)) begin
          res_status_nxt = sid_pkg::ST_MATCH;
          res_idx_nxt    = lo_r;
          state_nxt      = S_RES;
        end else begin
          sh_nxt    = count_r[ADDR_W-1:0];
          state_nxt = S_SH_RD;
        end
      end

      // Read the entry below the hole, or insert once the hole is at the position
      S_SH_RD: begin
        if (sh_r == lo_r) begin
          wr_en          = 1'b1;
          wr_addr        = lo_r;
          wr_data        = {1'b1, x_r};
          count_nxt      = count_r + CNT_W'(1);
          res_status_nxt = sid_pkg::ST_OK;
          res_idx_nxt    = lo_r;
          state_nxt      = S_RES;
        end else begin
          rd_addr   = sh_r - ADDR_W'(1);
          state_nxt = S_SH_WR;
        end
      end

      // Move the entry up one place
      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = sh_r;
        wr_data   = rd_data;
        sh_nxt    = sh_r - ADDR_W'(1);
        state_nxt = S_SH_RD;
      end

      // Hand the result to the output register once it frees
      S_RES: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = sid_pkg::INDEX_W'(res_idx_r);
          out_count_nxt  = sid_pkg::COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, table count, tolerance, search registers and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tol_r       <= sid_pkg::TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tol_r       <= tol_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r          <= x_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    sh_r         <= sh_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
  end

  // The table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(sid_pkg::TABLE_DEPTH))
    else $error("table count above depth");

  // A clear request empties the table
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.opcode == sid_pkg::OP_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the table");

  // The count grows by at most one per cycle or falls to zero
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1)
         || count_r == '0))
    else $error("table count jumped");

  // A match names an entry inside the table
  a_match_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == sid_pkg::ST_MATCH)
      |-> (sid_pkg::COUNT_W'(out_index_r) < out_count_r))
    else $error("match index outside the table");

endmodule
`default_nettype wire
